// ----- rtl/msoc_pkg.sv -----
// shared types and constants for the second-order motor compensator
`default_nettype none

package msoc_pkg;

	// width of the signed speed error and of its history
	localparam int ERROR_WIDTH = 16;

	// stream beat widths, rounded up to whole bytes
	localparam int IN_TDATA_W  = ((ERROR_WIDTH + 7) / 8) * 8;
	localparam int POWER_W     = 8;
	localparam int CONTROL_W   = 32;
	localparam int OUT_TDATA_W = POWER_W + CONTROL_W;

	// bracketed sum: exact width, never below the 48-bit clamp width
	localparam int S_CLAMP_W = 48;
	localparam int S_W       = (ERROR_WIDTH + 18 > S_CLAMP_W) ? ERROR_WIDTH + 18 : S_CLAMP_W;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// full-precision Q.22 accumulator
	localparam int T_W = 64;

	// configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// register indexes
	typedef enum logic [2:0] {
		REG_OUT_COEF_ONE = 3'd0,
		REG_OUT_COEF_TWO = 3'd1,
		REG_ERR_COEF_ONE = 3'd2,
		REG_ERR_COEF_TWO = 3'd3,
		REG_LOOP_GAIN    = 3'd4,
		REG_POWER_HI     = 3'd5,
		REG_POWER_LO     = 3'd6
	} reg_idx_t;

	// sequencer states, one multiply issued per ST_MUL step
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_X,
		ST_MUL_Y,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ACC_HI,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/motor_second_order_compensator_top.sv -----
// second-order discrete compensator with drive power saturation
//
// input stream: one beat carries one signed speed error per sample tick.
// output stream: one beat per input beat, carrying the drive power clamped
// between the lower and upper power limits and the Q24.8 control value
// saturated to 32 bits.
// configuration: APB-style port, registers at byte address 4*index; write
// only while no sample is in flight.
// sequencing: an accepted input beat runs through the steps MUL_A, MUL_B,
// MUL_X, MUL_Y, MUL_LO, MUL_HI, ACC_HI and DONE, whose end loads the result
// beat; a new input is accepted in the cycle after the result is loaded.
// The single shared 33x17 multiplier runs six products in turn (two error
// taps, two output taps and the gain product split into two halves), each
// product registered and folded into an accumulator in the next step.
// stall: the result sits in an output register; if it is not taken, the
// finished sample waits in its last step and s_tready stays low.
// reset: history and output valid clear, coefficients go to zero, gain to
// 1.0, power limits to +100 and -100.
`default_nettype none

module motor_second_order_compensator_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// input stream: [ERROR_WIDTH-1:0] speed_error
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [msoc_pkg::IN_TDATA_W-1:0]  s_tdata,
	// output stream: [7:0] drive_power, [39:8] control_value
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [msoc_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// configuration port
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [msoc_pkg::ADDR_W-1:0]      paddr,
	input  wire logic [msoc_pkg::DATA_W-1:0]      pwdata,
	output logic [msoc_pkg::DATA_W-1:0]           prdata,
	output logic                                  pready
);

	localparam int EW = msoc_pkg::ERROR_WIDTH;
	localparam int SW = msoc_pkg::S_W;
	localparam int TW = msoc_pkg::T_W;

	// configuration registers
	logic signed [15:0] out_coef_one_q, out_coef_two_q;
	logic signed [15:0] err_coef_one_q, err_coef_two_q;
	logic signed [15:0] loop_gain_q;
	logic signed [7:0]  power_hi_q, power_lo_q;

	// history
	logic signed [31:0]   last_output_q, older_output_q;
	logic signed [EW-1:0] last_error_q, older_error_q;

	// working registers
	msoc_pkg::state_t                      state_q, state_d;
	logic signed [EW-1:0]                  err_q;
	logic signed [SW-1:0]                  s_q;
	logic signed [msoc_pkg::S_CLAMP_W-1:0] sc_q;
	logic signed [TW-1:0]                  t_q;
	logic signed [msoc_pkg::MUL_P_W-1:0]   prod_q;

	// output register
	logic                                  out_valid_q;
	logic signed [7:0]                     power_q;
	logic signed [31:0]                    control_q;

	logic                                  wr_en;
	logic                                  in_beat;
	logic                                  out_load;

	// ---------------------------------------------------------------
	// configuration port

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_coef_one_q <= '0;
			out_coef_two_q <= '0;
			err_coef_one_q <= '0;
			err_coef_two_q <= '0;
			loop_gain_q    <= 16'sd256;
			power_hi_q     <= 8'sd100;
			power_lo_q     <= -8'sd100;
		end else if (wr_en) begin
			case (paddr[4:2])
				msoc_pkg::REG_OUT_COEF_ONE: out_coef_one_q <= pwdata[15:0];
				msoc_pkg::REG_OUT_COEF_TWO: out_coef_two_q <= pwdata[15:0];
				msoc_pkg::REG_ERR_COEF_ONE: err_coef_one_q <= pwdata[15:0];
				msoc_pkg::REG_ERR_COEF_TWO: err_coef_two_q <= pwdata[15:0];
				msoc_pkg::REG_LOOP_GAIN:    loop_gain_q    <= pwdata[15:0];
				msoc_pkg::REG_POWER_HI:     power_hi_q     <= pwdata[7:0];
				msoc_pkg::REG_POWER_LO:     power_lo_q     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register read
	always_comb begin
		case (paddr[4:2])
			msoc_pkg::REG_OUT_COEF_ONE: prdata = {16'h0000, out_coef_one_q};
			msoc_pkg::REG_OUT_COEF_TWO: prdata = {16'h0000, out_coef_two_q};
			msoc_pkg::REG_ERR_COEF_ONE: prdata = {16'h0000, err_coef_one_q};
			msoc_pkg::REG_ERR_COEF_TWO: prdata = {16'h0000, err_coef_two_q};
			msoc_pkg::REG_LOOP_GAIN:    prdata = {16'h0000, loop_gain_q};
			msoc_pkg::REG_POWER_HI:     prdata = {24'h000000, power_hi_q};
			msoc_pkg::REG_POWER_LO:     prdata = {24'h000000, power_lo_q};
			default:                    prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// sequencer

	assign s_tready = (state_q == msoc_pkg::ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign out_load = (state_q == msoc_pkg::ST_DONE) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msoc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			msoc_pkg::ST_IDLE:   if (s_tvalid) state_d = msoc_pkg::ST_MUL_A;
			msoc_pkg::ST_MUL_A:  state_d = msoc_pkg::ST_MUL_B;
			msoc_pkg::ST_MUL_B:  state_d = msoc_pkg::ST_MUL_X;
			msoc_pkg::ST_MUL_X:  state_d = msoc_pkg::ST_MUL_Y;
			msoc_pkg::ST_MUL_Y:  state_d = msoc_pkg::ST_MUL_LO;
			msoc_pkg::ST_MUL_LO: state_d = msoc_pkg::ST_MUL_HI;
			msoc_pkg::ST_MUL_HI: state_d = msoc_pkg::ST_ACC_HI;
			msoc_pkg::ST_ACC_HI: state_d = msoc_pkg::ST_DONE;
			msoc_pkg::ST_DONE:   if (out_load) state_d = msoc_pkg::ST_IDLE;
			default:             state_d = msoc_pkg::ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// shared multiplier

	logic signed [msoc_pkg::MUL_A_W-1:0] op_a;
	logic signed [msoc_pkg::MUL_B_W-1:0] op_b;
	logic signed [msoc_pkg::MUL_P_W-1:0] mul_p;

	// operand select per step
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			msoc_pkg::ST_MUL_A: begin
				op_a = msoc_pkg::MUL_A_W'(last_error_q);
				op_b = msoc_pkg::MUL_B_W'(err_coef_one_q);
			end
			msoc_pkg::ST_MUL_B: begin
				op_a = msoc_pkg::MUL_A_W'(older_error_q);
				op_b = msoc_pkg::MUL_B_W'(err_coef_two_q);
			end
			msoc_pkg::ST_MUL_X: begin
				op_a = msoc_pkg::MUL_A_W'(last_output_q);
				op_b = msoc_pkg::MUL_B_W'(out_coef_one_q);
			end
			msoc_pkg::ST_MUL_Y: begin
				op_a = msoc_pkg::MUL_A_W'(older_output_q);
				op_b = msoc_pkg::MUL_B_W'(out_coef_two_q);
			end
			msoc_pkg::ST_MUL_LO: begin
				// low half of the clamped sum, unsigned
				op_a = {9'b0_0000_0000, sc_q[23:0]};
				op_b = msoc_pkg::MUL_B_W'(loop_gain_q);
			end
			msoc_pkg::ST_MUL_HI: begin
				// high half of the clamped sum, signed
				op_a = msoc_pkg::MUL_A_W'($signed(sc_q[47:24]));
				op_b = msoc_pkg::MUL_B_W'(loop_gain_q);
			end
			default: ;
		endcase
	end

	assign mul_p = op_a * op_b;

	// ---------------------------------------------------------------
	// accumulators

	logic signed [EW-1:0]                  err_in;
	logic signed [SW-1:0]                  prod_s;
	logic signed [TW-1:0]                  prod_t;
	logic signed [TW-1:0]                  t_add;
	logic                                  s_ovf;
	logic signed [msoc_pkg::S_CLAMP_W-1:0] s_clamped;

	assign err_in = s_tdata[EW-1:0];
	assign prod_s = SW'(prod_q);
	assign prod_t = TW'(prod_q);

	// sum clamps to 48 bits when its upper bits disagree
	assign s_ovf     = !((&s_q[SW-1:47]) || !(|s_q[SW-1:47]));
	assign s_clamped = s_ovf ? (s_q[SW-1] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF)
	                         : s_q[47:0];

	// addend of the Q.22 accumulator per step
	always_comb begin
		t_add = '0;
		unique case (state_q)
			msoc_pkg::ST_MUL_Y:  t_add = -prod_t;
			msoc_pkg::ST_MUL_LO: t_add = -prod_t;
			msoc_pkg::ST_MUL_HI: t_add = prod_t;
			msoc_pkg::ST_ACC_HI: t_add = prod_t <<< 24;
			default: ;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (in_beat) begin
			err_q <= err_in;
			s_q   <= SW'(err_in) <<< 14;
			t_q   <= '0;
		end
		if (state_q == msoc_pkg::ST_MUL_B || state_q == msoc_pkg::ST_MUL_X) begin
			s_q <= s_q + prod_s;
		end
		if (state_q == msoc_pkg::ST_MUL_Y) begin
			sc_q <= s_clamped;
		end
		if (state_q == msoc_pkg::ST_MUL_Y || state_q == msoc_pkg::ST_MUL_LO ||
		    state_q == msoc_pkg::ST_MUL_HI || state_q == msoc_pkg::ST_ACC_HI) begin
			t_q <= t_q + t_add;
		end
	end

	// ---------------------------------------------------------------
	// shift, saturate and clamp

	logic               u_ok;
	logic signed [31:0] u_sat;
	logic signed [31:0] max_lim, min_lim;
	logic signed [7:0]  p_trunc;
	logic signed [7:0]  p_out;

	// floor shift by 14, then saturate to 32 bits
	assign u_ok  = (&t_q[63:45]) || !(|t_q[63:45]);
	assign u_sat = u_ok ? t_q[45:14] : (t_q[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

	assign max_lim = {{16{power_hi_q[7]}}, power_hi_q, 8'h00};
	assign min_lim = {{16{power_lo_q[7]}}, power_lo_q, 8'h00};

	// divide by 256 toward zero: floor, plus one for negative with a fraction
	assign p_trunc = u_sat[15:8] + {7'b000_0000, u_sat[31] & (|u_sat[7:0])};

	always_comb begin
		priority if (u_sat > max_lim) begin
			p_out = power_hi_q;
		end else if (u_sat < min_lim) begin
			p_out = power_lo_q;
		end else begin
			p_out = p_trunc;
		end
	end

	// history shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_output_q  <= '0;
			older_output_q <= '0;
			last_error_q   <= '0;
			older_error_q  <= '0;
		end else if (out_load) begin
			older_output_q <= last_output_q;
			last_output_q  <= u_sat;
			older_error_q  <= last_error_q;
			last_error_q   <= err_q;
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			power_q   <= p_out;
			control_q <= u_sat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {control_q, power_q};

	// ---------------------------------------------------------------
	// assertions

	// an accepted sample blocks the input until it is finished
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while a sample is in flight");

	// a new result beat only comes from the final step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == msoc_pkg::ST_DONE))
		else $error("result beat raised outside the final step");

	// a free output slot lets the final step finish at once
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msoc_pkg::ST_DONE && !m_tvalid) |=>
		(state_q == msoc_pkg::ST_IDLE && m_tvalid))
		else $error("final step stuck with a free output slot");

endmodule

`default_nettype wire
